// ===== rtl/mlft_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the learning bridge MAC table.
// Used by mlft_table and mac_learning_forward_table; depends on nothing.
package mlft_pkg;

    localparam int PORTS      = 8;
    localparam int MAC_W      = 48;
    localparam int AGE_W      = 16;
    localparam int ARRIVAL_W  = 3;
    localparam int OUT_PORT_W = 3;
    localparam int MASK_W     = 8;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;

    localparam logic [AGE_W-1:0] AGE_LIMIT_RST = 16'd300;

    typedef enum logic {
        FUNC_FRAME = 1'b0,
        FUNC_TICK  = 1'b1
    } func_t;

    typedef enum logic {
        REG_AGE_LIMIT = 1'b0,
        REG_NONE      = 1'b1
    } reg_idx_t;

    typedef struct packed {
        func_t                 func;
        logic [ARRIVAL_W-1:0]  arrival_port;
        logic [MAC_W-1:0]      src_mac;
        logic [MAC_W-1:0]      dst_mac;
    } item_t;

    typedef struct packed {
        logic                  hit;
        logic [OUT_PORT_W-1:0] out_port;
        logic [MASK_W-1:0]     port_mask;
    } result_t;

endpackage

// ===== rtl/mlft_table.sv =====
`timescale 1ns / 1ps
// Per-port MAC table: learning, ageing and destination lookup for one word.
// Depends on mlft_pkg for widths, item and result types.
module mlft_table (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          step,
    input  mlft_pkg::item_t               item,
    input  logic [mlft_pkg::AGE_W-1:0]    age_limit,
    output mlft_pkg::result_t             result
);

    logic [mlft_pkg::PORTS-1:0]  valid_reg;
    logic [mlft_pkg::PORTS-1:0]  valid_next;
    logic [mlft_pkg::MAC_W-1:0]  mac_reg  [mlft_pkg::PORTS];
    logic [mlft_pkg::MAC_W-1:0]  mac_next [mlft_pkg::PORTS];
    logic [mlft_pkg::AGE_W-1:0]  age_reg  [mlft_pkg::PORTS];
    logic [mlft_pkg::AGE_W-1:0]  age_next [mlft_pkg::PORTS];

    logic [mlft_pkg::MAC_W-1:0]  lrn_mac  [mlft_pkg::PORTS];
    logic [mlft_pkg::PORTS-1:0]  lrn_valid;
    logic [mlft_pkg::PORTS-1:0]  learn_sel;
    logic [mlft_pkg::PORTS-1:0]  match;
    logic [mlft_pkg::PORTS-1:0]  first;
    logic [mlft_pkg::PORTS-1:0]  flood;
    logic [mlft_pkg::PORTS-1:0]  sel_mask;
    logic [mlft_pkg::PORTS+mlft_pkg::MASK_W-1:0] wide_mask;
    logic [mlft_pkg::OUT_PORT_W-1:0] port;
    logic                        is_frame;
    logic                        in_range;

    assign is_frame = (item.func == mlft_pkg::FUNC_FRAME);
    assign in_range = (int'(item.arrival_port) < mlft_pkg::PORTS);

    // The lookup sees the table as it stands after this frame's learning.
    always_comb begin
        for (int k = 0; k < mlft_pkg::PORTS; k++) begin
            learn_sel[k] = is_frame && in_range && (int'(item.arrival_port) == k);
            lrn_valid[k] = valid_reg[k] | learn_sel[k];
            lrn_mac[k]   = (learn_sel[k] && !valid_reg[k]) ? item.src_mac : mac_reg[k];
            match[k]     = lrn_valid[k] && (lrn_mac[k] == item.dst_mac);
            flood[k]     = (int'(item.arrival_port) != k);
        end
    end

    assign first = match & (~match + mlft_pkg::PORTS'(1));

    always_comb begin
        port = '0;
        for (int k = mlft_pkg::PORTS - 1; k >= 0; k--) begin
            if (match[k]) begin
                port = mlft_pkg::OUT_PORT_W'(k);
            end
        end
    end

    assign sel_mask  = (|match) ? first : flood;
    assign wide_mask = {{mlft_pkg::MASK_W{1'b0}}, sel_mask};

    assign result.hit       = |match;
    assign result.out_port  = port;
    assign result.port_mask = wide_mask[mlft_pkg::MASK_W-1:0];

    always_comb begin
        valid_next = valid_reg;
        for (int k = 0; k < mlft_pkg::PORTS; k++) begin
            mac_next[k] = mac_reg[k];
            age_next[k] = age_reg[k];
            if (!is_frame) begin
                if (valid_reg[k]) begin
                    if (age_reg[k] <= mlft_pkg::AGE_W'(1)) begin
                        valid_next[k] = 1'b0;
                    end else begin
                        age_next[k] = age_reg[k] - mlft_pkg::AGE_W'(1);
                    end
                end
            end else if (learn_sel[k]) begin
                valid_next[k] = 1'b1;
                mac_next[k]   = lrn_mac[k];
                age_next[k]   = age_limit;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (step) begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            for (int k = 0; k < mlft_pkg::PORTS; k++) begin
                mac_reg[k] <= mac_next[k];
                age_reg[k] <= age_next[k];
            end
        end
    end

    // A frame on a port that exists always leaves that port's entry valid.
    a_learn_sets_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        step && is_frame && in_range |=>
            ((valid_reg & $past(learn_sel)) == $past(learn_sel)))
        else $error("learned entry is not valid after a frame");

    // Ageing can only remove entries, never create them.
    a_tick_no_new_entry: assert property (@(posedge aclk) disable iff (!aresetn)
        step && !is_frame |=> ((valid_reg & ~$past(valid_reg)) == '0))
        else $error("tick made an entry valid");

    // A hit selects exactly one valid entry.
    a_hit_one_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        result.hit |-> ($onehot(first) && ((first & lrn_valid) == first)))
        else $error("hit does not select a single valid entry");

endmodule

// ===== rtl/mac_learning_forward_table.sv =====
`timescale 1ns / 1ps
// Top level of the learning bridge MAC table: input register, table, result register, APB.
// Depends on mlft_pkg and mlft_table.
//
// The block takes one word per clock cycle, frames and ageing ticks alike, unless a frame is
// stalled. A frame's result is registered as the frame leaves the input register, since the
// eight-entry learn and compare runs against the table while the word sits in the input
// register. A frame waits there, and the input stalls, while an earlier result is held back
// by m_ready. Ticks produce no result and pass even while a result waits to be taken. The
// table starts empty after reset with no clearing pass. The user must write age_limit over
// APB at byte address 0 only while no word is in flight; the block does not enforce this.
module mac_learning_forward_table (
    input  logic                               aclk,
    input  logic                               aresetn,

    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic                               s_func,
    input  logic [mlft_pkg::ARRIVAL_W-1:0]     s_arrival_port,
    input  logic [mlft_pkg::MAC_W-1:0]         s_src_mac,
    input  logic [mlft_pkg::MAC_W-1:0]         s_dst_mac,

    output logic                               m_valid,
    input  logic                               m_ready,
    output logic                               m_hit,
    output logic [mlft_pkg::OUT_PORT_W-1:0]    m_out_port,
    output logic [mlft_pkg::MASK_W-1:0]        m_port_mask,

    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [mlft_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [mlft_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [mlft_pkg::APB_DATA_W-1:0]    prdata,
    output logic                               pready
);

    logic                          in_valid_reg;
    logic                          in_valid_next;
    mlft_pkg::item_t               item_reg;
    logic                          m_valid_reg;
    logic                          m_valid_next;
    mlft_pkg::result_t             res_reg;
    mlft_pkg::result_t             res;
    logic [mlft_pkg::AGE_W-1:0]    age_limit_reg;
    logic                          advance;
    logic                          accept;
    logic                          is_tick;
    logic                          cfg_write;
    mlft_pkg::reg_idx_t            reg_idx;

    assign reg_idx   = mlft_pkg::reg_idx_t'(paddr[2]);
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (reg_idx == mlft_pkg::REG_AGE_LIMIT);

    always_comb begin
        case (reg_idx)
            mlft_pkg::REG_AGE_LIMIT: begin
                prdata = {{(mlft_pkg::APB_DATA_W - mlft_pkg::AGE_W){1'b0}}, age_limit_reg};
            end
            default: begin
                prdata = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            age_limit_reg <= mlft_pkg::AGE_LIMIT_RST;
        end else if (cfg_write) begin
            age_limit_reg <= pwdata[mlft_pkg::AGE_W-1:0];
        end
    end

    assign is_tick = (item_reg.func == mlft_pkg::FUNC_TICK);
    assign advance = in_valid_reg && (is_tick || !m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign accept  = s_valid && s_ready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (accept) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg && !m_ready;
        if (advance && !is_tick) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            item_reg.func         <= mlft_pkg::func_t'(s_func);
            item_reg.arrival_port <= s_arrival_port;
            item_reg.src_mac      <= s_src_mac;
            item_reg.dst_mac      <= s_dst_mac;
        end
        if (advance && !is_tick) begin
            res_reg <= res;
        end
    end

    mlft_table u_table (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (advance),
        .item      (item_reg),
        .age_limit (age_limit_reg),
        .result    (res)
    );

    assign m_valid     = m_valid_reg;
    assign m_hit       = res_reg.hit;
    assign m_out_port  = res_reg.out_port;
    assign m_port_mask = res_reg.port_mask;

endmodule
